// File: hdl/clc_pkg.sv
`default_nettype none

package clc_pkg;

	localparam int CARD_W    = 63;
	localparam int DIGITS    = 19;
	localparam int DIGIT_W   = 4;
	localparam int BCD_W     = DIGITS * DIGIT_W;
	localparam int COUNT_W   = 5;
	localparam int BRAND_W   = 2;
	localparam int BITCNT_W  = 6;

	localparam logic [BRAND_W-1:0] BRAND_NONE  = 2'd0;
	localparam logic [BRAND_W-1:0] BRAND_P4    = 2'd1;
	localparam logic [BRAND_W-1:0] BRAND_P34   = 2'd2;
	localparam logic [BRAND_W-1:0] BRAND_P51   = 2'd3;

	localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
	localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
	localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;
	localparam logic [4:0]         TEN    = 5'd10;

	// one decimal digit handed from the converter to the checker
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [DIGIT_W-1:0] digit;
	} digit_t;

endpackage

`default_nettype wire

// File: hdl/clc_card_if.sv
`default_nettype none

interface clc_card_if;
	logic                         valid;
	logic                         ready;
	logic [clc_pkg::CARD_W-1:0]   card_number;

	modport source (output valid, output card_number, input ready);
	modport sink   (input valid, input card_number, output ready);
endinterface

`default_nettype wire

// File: hdl/clc_result_if.sv
`default_nettype none

interface clc_result_if;
	logic                         valid;
	logic                         ready;
	logic [clc_pkg::BRAND_W-1:0]  brand;
	logic                         luhn_ok;
	logic [clc_pkg::COUNT_W-1:0]  digit_count;

	modport source (output valid, output brand, output luhn_ok, output digit_count,
		input ready);
	modport sink   (input valid, input brand, input luhn_ok, input digit_count,
		output ready);
endinterface

`default_nettype wire

// File: hdl/clc_bcd_conv.sv
`default_nettype none

// Shift-and-add-3 binary to BCD, one input bit per cycle, then the digits
// are shifted out least significant first, one per cycle.
module clc_bcd_conv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [clc_pkg::CARD_W-1:0]  value,
	output clc_pkg::digit_t                  dig
);

	typedef enum logic [1:0] {IDLE, CONV, EMIT} conv_state_t;

	conv_state_t                       state_q;
	logic [clc_pkg::BITCNT_W-1:0]      cnt_q;
	logic [clc_pkg::CARD_W-1:0]        bin_q;
	logic [clc_pkg::BCD_W-1:0]         bcd_q;
	logic [clc_pkg::BCD_W-1:0]         bcd_adj;

	always_comb begin
		for (int i = 0; i < clc_pkg::DIGITS; i++) begin
			if (bcd_q[i*clc_pkg::DIGIT_W +: clc_pkg::DIGIT_W] >= 4'd5) begin
				bcd_adj[i*clc_pkg::DIGIT_W +: clc_pkg::DIGIT_W] =
					bcd_q[i*clc_pkg::DIGIT_W +: clc_pkg::DIGIT_W] + 4'd3;
			end else begin
				bcd_adj[i*clc_pkg::DIGIT_W +: clc_pkg::DIGIT_W] =
					bcd_q[i*clc_pkg::DIGIT_W +: clc_pkg::DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= CONV;
						cnt_q   <= '0;
					end
				end
				CONV: begin
					if (cnt_q == clc_pkg::BITCNT_W'(clc_pkg::CARD_W - 1)) begin
						state_q <= EMIT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				EMIT: begin
					if (cnt_q == clc_pkg::BITCNT_W'(clc_pkg::DIGITS - 1)) begin
						state_q <= IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				if (start) begin
					bin_q <= value;
					bcd_q <= '0;
				end
			end
			CONV: begin
				bcd_q <= {bcd_adj[clc_pkg::BCD_W-2:0], bin_q[clc_pkg::CARD_W-1]};
				bin_q <= {bin_q[clc_pkg::CARD_W-2:0], 1'b0};
			end
			EMIT: bcd_q <= {{clc_pkg::DIGIT_W{1'b0}}, bcd_q[clc_pkg::BCD_W-1:clc_pkg::DIGIT_W]};
			default: ;
		endcase
	end

	assign dig = '{
		valid: (state_q == EMIT),
		last:  (state_q == EMIT) && (cnt_q == clc_pkg::BITCNT_W'(clc_pkg::DIGITS - 1)),
		digit: bcd_q[clc_pkg::DIGIT_W-1:0]
	};

endmodule

`default_nettype wire

// File: hdl/card_number_luhn_classifier.sv
`default_nettype none

// Luhn mod-10 check and brand classification of one card number. A number
// is converted to decimal one bit per cycle, then its 19 digits are walked
// one per cycle from the least significant end, and then the result
// register is loaded as soon as it is free. The next number can be taken
// after that load, so the block works on one number at a time. The next
// number is taken while a result still waits to be transferred. The block
// holds no state between numbers.
module card_number_luhn_classifier (
	input  wire logic     clk,
	input  wire logic     arst_n,
	clc_card_if.sink      card_in,
	clc_result_if.source  result
);

	typedef enum logic [1:0] {IDLE, RUN, HOLD} top_state_t;

	top_state_t                         state_q;
	clc_pkg::digit_t                    dig;
	logic                               in_xfer;
	logic                               out_load;

	logic [clc_pkg::COUNT_W-1:0]        pos_q;
	logic [clc_pkg::COUNT_W-1:0]        count_q;
	logic [3:0]                         sum_q;
	logic [clc_pkg::DIGIT_W-1:0]        lead_q;
	logic [clc_pkg::DIGIT_W-1:0]        second_q;
	logic [clc_pkg::DIGIT_W-1:0]        prev_q;

	logic [clc_pkg::COUNT_W-1:0]        pos_next;
	logic [4:0]                         contrib;
	logic [4:0]                         sum_raw;
	logic [3:0]                         sum_next;
	logic                               ok;
	logic [clc_pkg::BRAND_W-1:0]        brand_c;

	logic                               out_valid_q;
	logic [clc_pkg::BRAND_W-1:0]        brand_q;
	logic                               ok_q;
	logic [clc_pkg::COUNT_W-1:0]        dcount_q;

	assign in_xfer       = card_in.valid && card_in.ready;
	assign card_in.ready = (state_q == IDLE);
	assign out_load      = (state_q == HOLD) && (!out_valid_q || result.ready);

	clc_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.value  (card_in.card_number),
		.dig    (dig)
	);

	// doubled digits contribute 2d, less 9 once the product has two digits
	always_comb begin
		pos_next = pos_q + 1'b1;
		if (!pos_next[0]) begin
			if (dig.digit >= 4'd5) begin
				contrib = {dig.digit, 1'b0} - 5'd9;
			end else begin
				contrib = {dig.digit, 1'b0};
			end
		end else begin
			contrib = {1'b0, dig.digit};
		end
		sum_raw = {1'b0, sum_q} + contrib;
		if (sum_raw >= clc_pkg::TEN) begin
			sum_next = 4'(sum_raw - clc_pkg::TEN);
		end else begin
			sum_next = sum_raw[3:0];
		end
	end

	always_comb begin
		ok      = (sum_q == 4'd0);
		brand_c = clc_pkg::BRAND_NONE;
		if (ok) begin
			if (lead_q == 4'd4 && (count_q == clc_pkg::LEN_16 ||
				count_q == clc_pkg::LEN_13)) begin
				brand_c = clc_pkg::BRAND_P4;
			end else if (lead_q == 4'd3 && (second_q inside {4'd4, 4'd7}) &&
				count_q == clc_pkg::LEN_15) begin
				brand_c = clc_pkg::BRAND_P34;
			end else if (lead_q == 4'd5 && (second_q inside {[4'd1:4'd5]}) &&
				count_q == clc_pkg::LEN_16) begin
				brand_c = clc_pkg::BRAND_P51;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			lead_q      <= '0;
			second_q    <= '0;
			prev_q      <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_xfer) begin
						state_q  <= RUN;
						pos_q    <= '0;
						count_q  <= '0;
						sum_q    <= '0;
						lead_q   <= '0;
						second_q <= '0;
						prev_q   <= '0;
					end
				end
				RUN: begin
					if (dig.valid) begin
						pos_q  <= pos_next;
						sum_q  <= sum_next;
						prev_q <= dig.digit;
						if (dig.digit != 4'd0) begin
							count_q  <= pos_next;
							lead_q   <= dig.digit;
							second_q <= prev_q;
						end
						if (dig.last) begin
							state_q <= HOLD;
						end
					end
				end
				HOLD: begin
					if (out_load) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			brand_q  <= brand_c;
			ok_q     <= ok;
			dcount_q <= count_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.brand       = brand_q;
	assign result.luhn_ok     = ok_q;
	assign result.digit_count = dcount_q;

	a_digit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> state_q == RUN)
		else $error("digit delivered outside the walk");

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == RUN && !dig.valid)
		else $error("transfer did not start conversion");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q < 4'd10 && count_q <= pos_q)
		else $error("running sum or digit count out of range");

	a_brand_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.brand != clc_pkg::BRAND_NONE |-> result.luhn_ok)
		else $error("brand given for a failing number");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || result.ready)
		else $error("result register overwritten");

endmodule

`default_nettype wire
